### hw/rtl/char_lcd_init_write_sequencer_defines.svh
// Assertion macros used by the LCD sequencer top level.
`ifndef CHAR_LCD_INIT_WRITE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_INIT_WRITE_SEQUENCER_DEFINES_SVH

`ifndef SYNTH

// Check that a holds implies b holds in the same cycle.
`define LCDSEQ_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("lcdseq same-cycle check failed");

// Check that a holds implies b holds in the next cycle.
`define LCDSEQ_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("lcdseq next-cycle check failed");

`else

`define LCDSEQ_ASSERT_SAME(label, clk, rst_n, a, b)
`define LCDSEQ_ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

### hw/rtl/lcdseq_pkg.sv
// Types, constants and helpers of the character LCD sequencer.
package lcdseq_pkg;

    localparam int TIMER_BITS_DEFAULT = 16;
    localparam int CFG_W              = 16;
    localparam int CFG_COUNT          = 8;
    localparam int CFG_IDX_W          = 3;

    // Request command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_INIT  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_WAIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_WAIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_WAIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_UP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_RESET  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LATER_RESET  = 3'd7;

    typedef logic [CFG_W-1:0] cfg_word_t;
    typedef cfg_word_t [CFG_COUNT-1:0] cfg_regs_t;

    localparam cfg_regs_t CFG_RESET = {
        16'd1000, 16'd5000, 16'd15000, 16'd2000,
        16'd37,   16'd41,   16'd20,    16'd20
    };

    typedef enum logic [3:0] {
        STEP_IDLE   = 4'd0,
        STEP_POWER  = 4'd1,
        STEP_RESET1 = 4'd2,
        STEP_RESET2 = 4'd3,
        STEP_RESET3 = 4'd4,
        STEP_FUNC   = 4'd5,
        STEP_DISP   = 4'd6,
        STEP_ENTRY  = 4'd7,
        STEP_CLEAR  = 4'd8,
        STEP_CHAR   = 4'd9
    } step_t;

    typedef enum logic [1:0] {
        PH_NONE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2,
        PH_WAIT = 2'd3
    } phase_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] char_code;
    } item_t;

    typedef struct packed {
        logic       rs_line;
        logic       enable_line;
        logic [7:0] data_bus;
        logic       busy_res;
        logic       initialized;
        logic       accepted;
    } result_t;

    // Sequencer control state apart from the wait counter
    typedef struct packed {
        step_t      step;
        phase_t     phase;
        logic       rs;
        logic       en;
        logic [7:0] bus;
        logic       init_done;
    } ctl_t;

    // Bus byte written by each init step
    function automatic logic [7:0] step_byte(input step_t s);
        logic [7:0] b;
        unique case (s)
            STEP_RESET1, STEP_RESET2, STEP_RESET3: b = 8'h30;
            STEP_FUNC:                             b = 8'h38;
            STEP_DISP:                             b = 8'h0E;
            STEP_ENTRY:                            b = 8'h06;
            STEP_CLEAR:                            b = 8'h01;
            default:                               b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### hw/rtl/char_lcd_init_write_sequencer.sv
// Top level of the 8-bit character LCD init and write sequencer.
//
//  Channel   Direction  Handshake                  Content
//  item      in         item_valid/item_stall      command, char_code
//  result    out        result_valid/result_stall  rs_line, enable_line, data_bus,
//                                                  busy_res, initialized, accepted
//  cfg       in         cfg_we (write only)        cfg_index, cfg_wdata
//
// One request per clock while item_stall is low: the step logic updates the
// sequencer and its result loads the result register at the accepting edge.
// A one-entry skid behind the result register takes one more request while
// result_stall is high; item_stall rises only once it fills.
// rst_n clears the sequencer to idle with pins low and reloads power-on timing.
module char_lcd_init_write_sequencer #(
    parameter int TIMER_BITS = lcdseq_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  lcdseq_pkg::item_t                   item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output lcdseq_pkg::result_t                 result,
    input  logic                                cfg_we,
    input  logic [lcdseq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  lcdseq_pkg::cfg_word_t               cfg_wdata
);

`include "char_lcd_init_write_sequencer_defines.svh"

    // Timing registers
    lcdseq_pkg::cfg_regs_t cfg_reg;

    // Sequencer state
    lcdseq_pkg::ctl_t      ctl_reg;
    lcdseq_pkg::ctl_t      ctl_next;
    logic [TIMER_BITS-1:0] wait_reg;
    logic [TIMER_BITS-1:0] wait_next;

    // Result register and skid entry
    lcdseq_pkg::result_t   step_result;
    lcdseq_pkg::result_t   out_reg;
    lcdseq_pkg::result_t   out_next;
    lcdseq_pkg::result_t   skid_reg;
    lcdseq_pkg::result_t   skid_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  skid_valid_reg;
    logic                  skid_valid_next;

    logic                  item_take;
    logic                  result_take;

    assign item_stall   = skid_valid_reg;
    assign item_take    = item_valid && !skid_valid_reg;
    assign result_take  = out_valid_reg && !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Configuration writes land directly; the user must keep the block idle when they come, as it does not check
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= lcdseq_pkg::CFG_RESET;
        else if (cfg_we)
            cfg_reg[cfg_index] <= cfg_wdata;
    end

    lcdseq_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .item      (item),
        .cfg       (cfg_reg),
        .ctl       (ctl_reg),
        .wait_cnt  (wait_reg),
        .ctl_next  (ctl_next),
        .wait_next (wait_next),
        .result    (step_result)
    );

    // Advance the sequencer only on an accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.step      <= lcdseq_pkg::STEP_IDLE;
            ctl_reg.phase     <= lcdseq_pkg::PH_NONE;
            ctl_reg.rs        <= 1'b0;
            ctl_reg.en        <= 1'b0;
            ctl_reg.bus       <= 8'h00;
            ctl_reg.init_done <= 1'b0;
            wait_reg          <= '0;
        end
        else if (item_take)
        begin
            ctl_reg  <= ctl_next;
            wait_reg <= wait_next;
        end
    end

    // Result steering: drain the skid first, hold while stalled, park
    // a fresh result in the skid when the result register is held
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (!out_valid_reg || result_take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = step_result;
                out_valid_next = item_take;
            end
        end
        else if (item_take)
        begin
            skid_next       = step_result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // Skid never holds a result ahead of an empty result register
    `LCDSEQ_ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)

    // A request taken while the result is held lands in the skid
    `LCDSEQ_ASSERT_NEXT(a_held_goes_to_skid, clk, rst_n,
        out_valid_reg && result_stall && item_take, skid_valid_reg)

    // Enable is high only during the high phase of a pulse
    `LCDSEQ_ASSERT_SAME(a_enable_in_high, clk, rst_n,
        ctl_reg.en, ctl_reg.phase == lcdseq_pkg::PH_HIGH)

    // Idle sequencer carries no pulse or wait phase
    `LCDSEQ_ASSERT_SAME(a_idle_no_phase, clk, rst_n,
        ctl_reg.step == lcdseq_pkg::STEP_IDLE, ctl_reg.phase == lcdseq_pkg::PH_NONE)

endmodule

### hw/rtl/lcdseq_step.sv
// Next-state and result logic for one request of the LCD sequencer.
module lcdseq_step #(
    parameter int TIMER_BITS = lcdseq_pkg::TIMER_BITS_DEFAULT
) (
    input  lcdseq_pkg::item_t     item,
    input  lcdseq_pkg::cfg_regs_t cfg,
    input  lcdseq_pkg::ctl_t      ctl,
    input  logic [TIMER_BITS-1:0] wait_cnt,
    output lcdseq_pkg::ctl_t      ctl_next,
    output logic [TIMER_BITS-1:0] wait_next,
    output lcdseq_pkg::result_t   result
);

    localparam int WB = (TIMER_BITS > lcdseq_pkg::CFG_W) ? TIMER_BITS : lcdseq_pkg::CFG_W;

    // Saturate a register value to the timer range
    function automatic logic [TIMER_BITS-1:0] lim(input lcdseq_pkg::cfg_word_t v);
        logic [WB-1:0] e;
        logic [WB-1:0] m;
        e = WB'(v);
        m = WB'({TIMER_BITS{1'b1}});
        return (e > m) ? TIMER_BITS'(m) : TIMER_BITS'(e);
    endfunction

    function automatic logic [TIMER_BITS-1:0] at_least_one(input lcdseq_pkg::cfg_word_t v);
        logic [TIMER_BITS-1:0] l;
        l = lim(v);
        return (l == '0) ? TIMER_BITS'(1) : l;
    endfunction

    lcdseq_pkg::cfg_word_t post_wait_raw;
    logic [TIMER_BITS-1:0] post_wait;
    logic [TIMER_BITS-1:0] power_wait;
    logic [TIMER_BITS-1:0] high_time;
    logic [TIMER_BITS-1:0] low_time;
    logic                  idle;
    logic                  fin;
    logic                  acc;
    lcdseq_pkg::step_t     step_inc;

    // Post-write wait follows the step being finished
    always_comb
    begin
        unique case (ctl.step) inside
            lcdseq_pkg::STEP_RESET1:
                post_wait_raw = cfg[lcdseq_pkg::CFG_FIRST_RESET];
            lcdseq_pkg::STEP_RESET2, lcdseq_pkg::STEP_RESET3:
                post_wait_raw = cfg[lcdseq_pkg::CFG_LATER_RESET];
            lcdseq_pkg::STEP_FUNC, lcdseq_pkg::STEP_DISP, lcdseq_pkg::STEP_ENTRY:
                post_wait_raw = cfg[lcdseq_pkg::CFG_COMMAND_WAIT];
            lcdseq_pkg::STEP_CLEAR:
                post_wait_raw = cfg[lcdseq_pkg::CFG_CLEAR_WAIT];
            default:
                post_wait_raw = cfg[lcdseq_pkg::CFG_CHAR_WAIT];
        endcase
    end

    assign post_wait  = lim(post_wait_raw);
    assign power_wait = lim(cfg[lcdseq_pkg::CFG_POWER_UP]);
    assign high_time  = at_least_one(cfg[lcdseq_pkg::CFG_ENABLE_HIGH]);
    assign low_time   = at_least_one(cfg[lcdseq_pkg::CFG_ENABLE_LOW]);
    assign idle       = (ctl.step == lcdseq_pkg::STEP_IDLE);

    always_comb
    begin
        ctl_next  = ctl;
        wait_next = wait_cnt;
        fin       = 1'b0;
        acc       = 1'b0;
        step_inc  = lcdseq_pkg::STEP_IDLE;

        case (item.command)
            lcdseq_pkg::CMD_TICK:
            begin
                if (idle || ctl.phase == lcdseq_pkg::PH_NONE)
                begin
                    ctl_next.step  = lcdseq_pkg::STEP_IDLE;
                    ctl_next.phase = lcdseq_pkg::PH_NONE;
                    ctl_next.en    = 1'b0;
                    wait_next      = '0;
                end
                else if (wait_cnt > TIMER_BITS'(1))
                begin
                    wait_next = wait_cnt - TIMER_BITS'(1);
                end
                else if (ctl.phase == lcdseq_pkg::PH_HIGH)
                begin
                    ctl_next.en    = 1'b0;
                    ctl_next.phase = lcdseq_pkg::PH_LOW;
                    wait_next      = low_time;
                end
                else if (ctl.phase == lcdseq_pkg::PH_LOW)
                begin
                    if (post_wait == '0)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        ctl_next.phase = lcdseq_pkg::PH_WAIT;
                        wait_next      = post_wait;
                    end
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            lcdseq_pkg::CMD_INIT:
            begin
                if (idle)
                begin
                    acc                = 1'b1;
                    ctl_next.init_done = 1'b0;
                    ctl_next.rs        = 1'b0;
                    ctl_next.en        = 1'b0;
                    ctl_next.step      = lcdseq_pkg::STEP_POWER;
                    wait_next          = power_wait;
                    if (power_wait == '0)
                        fin = 1'b1;
                    else
                        ctl_next.phase = lcdseq_pkg::PH_WAIT;
                end
            end
            lcdseq_pkg::CMD_WRITE:
            begin
                if (idle && ctl.init_done)
                begin
                    acc            = 1'b1;
                    ctl_next.rs    = 1'b1;
                    ctl_next.step  = lcdseq_pkg::STEP_CHAR;
                    ctl_next.bus   = item.char_code;
                    ctl_next.en    = 1'b1;
                    ctl_next.phase = lcdseq_pkg::PH_HIGH;
                    wait_next      = high_time;
                end
            end
            default:
            begin
                acc = 1'b0;
            end
        endcase

        // Close the step: chain into the next init write, or drop to idle
        if (fin)
        begin
            step_inc = lcdseq_pkg::step_t'(4'(ctl_next.step) + 4'd1);
            if (ctl_next.step >= lcdseq_pkg::STEP_POWER && ctl_next.step <= lcdseq_pkg::STEP_ENTRY)
            begin
                ctl_next.step  = step_inc;
                ctl_next.bus   = lcdseq_pkg::step_byte(step_inc);
                ctl_next.en    = 1'b1;
                ctl_next.phase = lcdseq_pkg::PH_HIGH;
                wait_next      = high_time;
            end
            else
            begin
                if (ctl_next.step == lcdseq_pkg::STEP_CLEAR)
                    ctl_next.init_done = 1'b1;
                ctl_next.step  = lcdseq_pkg::STEP_IDLE;
                ctl_next.phase = lcdseq_pkg::PH_NONE;
                wait_next      = '0;
            end
        end
    end

    assign result.rs_line     = ctl_next.rs;
    assign result.enable_line = ctl_next.en;
    assign result.data_bus    = ctl_next.bus;
    assign result.busy_res    = (ctl_next.step != lcdseq_pkg::STEP_IDLE);
    assign result.initialized = ctl_next.init_done;
    assign result.accepted    = acc;

endmodule

### bench/tb_top.sv
// Self-checking bench for the character LCD init and write sequencer.
`timescale 1ns / 100ps

module tb_top;

    import lcdseq_pkg::*;

    // Code 3 is outside the command set; the block must refuse it.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // Bytes the init sequence puts on the bus
    localparam logic [7:0] LCD_SOFT_RESET = 8'h30;
    localparam logic [7:0] LCD_FUNC_SET   = 8'h38;
    localparam logic [7:0] LCD_DISP_ON    = 8'h0E;
    localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] LCD_CLEAR      = 8'h01;

    localparam cfg_word_t TIME_MAX       = 16'hFFFF;
    localparam int        WATCHDOG_LIMIT = 5000;
    localparam int        RANDOM_PHASES  = 8;
    localparam int        PHASE_REQUESTS = 240;
    // Ticks fed at the start of the longest power-up.
    localparam int        LONG_WAIT_TICKS = 20;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_stall;
    item_t     item         = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    result_t   result;
    logic      cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    cfg_word_t cfg_wdata    = '0;

    // Requests waiting for the driver, and pin states waiting for the monitor
    item_t   pending_requests [$];
    result_t expected_pins [$];

    // Mirror of the sequencer: step, pulse phase, wait count, pins, timing
    step_t       lcd_step  = STEP_IDLE;
    phase_t      lcd_phase = PH_NONE;
    logic [15:0] lcd_wait  = '0;
    logic        lcd_rs    = 1'b0;
    logic        lcd_en    = 1'b0;
    logic [7:0]  lcd_bus   = '0;
    logic        lcd_init  = 1'b0;
    cfg_word_t   lcd_cfg [CFG_COUNT];
    cfg_word_t   timing_plan [CFG_COUNT];

    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    int unsigned stall_draw   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatches   = 0;
    logic        calm         = 1'b0;

    char_lcd_init_write_sequencer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sequencer mirror
    // ------------------------------------------------------------------

    // An enable time of zero still holds the line for one tick.
    function automatic logic [15:0] pulse_len(input cfg_word_t v);
        return (v == '0) ? 16'd1 : v;
    endfunction

    function automatic logic [7:0] init_byte(input step_t s);
        logic [7:0] b;
        case (s)
            STEP_RESET1, STEP_RESET2, STEP_RESET3: b = LCD_SOFT_RESET;
            STEP_FUNC:                             b = LCD_FUNC_SET;
            STEP_DISP:                             b = LCD_DISP_ON;
            STEP_ENTRY:                            b = LCD_ENTRY_MODE;
            STEP_CLEAR:                            b = LCD_CLEAR;
            default:                               b = 8'h00;
        endcase
        return b;
    endfunction

    // Put a byte on the bus and raise E for the enable-high time.
    function automatic void start_write(input step_t s, input logic [7:0] b);
        lcd_step  = s;
        lcd_bus   = b;
        lcd_en    = 1'b1;
        lcd_phase = PH_HIGH;
        lcd_wait  = pulse_len(lcd_cfg[CFG_ENABLE_HIGH]);
    endfunction

    // Leave the current step: start the next init write, or drop to idle.
    function automatic void advance_step();
        step_t nx;
        if (lcd_step >= STEP_POWER && lcd_step <= STEP_ENTRY)
        begin
            nx = step_t'(lcd_step + 1);
            start_write(nx, init_byte(nx));
        end
        else
        begin
            if (lcd_step == STEP_CLEAR)
                lcd_init = 1'b1;
            lcd_step  = STEP_IDLE;
            lcd_phase = PH_NONE;
            lcd_wait  = '0;
        end
    endfunction

    // Apply one request to the mirror and return the pins it should leave.
    function automatic result_t predict_request(input item_t req);
        result_t   r;
        logic      took;
        cfg_word_t hold;
        took = 1'b0;
        if (req.command == CMD_TICK)
        begin
            if (lcd_step == STEP_IDLE || lcd_phase == PH_NONE)
            begin
                lcd_step  = STEP_IDLE;
                lcd_phase = PH_NONE;
                lcd_wait  = '0;
                lcd_en    = 1'b0;
            end
            else if (lcd_wait > 16'd1)
                lcd_wait = lcd_wait - 16'd1;
            else if (lcd_phase == PH_HIGH)
            begin
                lcd_en    = 1'b0;
                lcd_phase = PH_LOW;
                lcd_wait  = pulse_len(lcd_cfg[CFG_ENABLE_LOW]);
            end
            else if (lcd_phase == PH_LOW)
            begin
                // Each write has its own settle time after E drops.
                case (lcd_step)
                    STEP_RESET1:                     hold = lcd_cfg[CFG_FIRST_RESET];
                    STEP_RESET2, STEP_RESET3:        hold = lcd_cfg[CFG_LATER_RESET];
                    STEP_FUNC, STEP_DISP, STEP_ENTRY: hold = lcd_cfg[CFG_COMMAND_WAIT];
                    STEP_CLEAR:                      hold = lcd_cfg[CFG_CLEAR_WAIT];
                    default:                         hold = lcd_cfg[CFG_CHAR_WAIT];
                endcase
                if (hold == '0)
                    advance_step();
                else
                begin
                    lcd_phase = PH_WAIT;
                    lcd_wait  = hold;
                end
            end
            else
                advance_step();
        end
        else if (req.command == CMD_INIT && lcd_step == STEP_IDLE)
        begin
            took      = 1'b1;
            lcd_init  = 1'b0;
            lcd_rs    = 1'b0;
            lcd_en    = 1'b0;
            lcd_step  = STEP_POWER;
            lcd_wait  = lcd_cfg[CFG_POWER_UP];
            if (lcd_wait == '0)
                advance_step();
            else
                lcd_phase = PH_WAIT;
        end
        else if (req.command == CMD_WRITE && lcd_step == STEP_IDLE && lcd_init)
        begin
            took   = 1'b1;
            lcd_rs = 1'b1;
            start_write(STEP_CHAR, req.char_code);
        end
        r.rs_line     = lcd_rs;
        r.enable_line = lcd_en;
        r.data_bus    = lcd_bus;
        r.busy_res    = (lcd_step != STEP_IDLE);
        r.initialized = lcd_init;
        r.accepted    = took;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic item_t make_request(input logic [1:0] cmd, input logic [7:0] code);
        item_t r;
        r.command   = cmd;
        r.char_code = code;
        return r;
    endfunction

    // Mostly ticks, so sequences run to the end; the rest are commands,
    // many of them landing while busy and being refused.
    function automatic item_t random_request();
        int unsigned roll;
        logic [1:0]  cmd;
        roll = $urandom_range(99);
        if (roll < 64)
            cmd = CMD_TICK;
        else if (roll < 86)
            cmd = CMD_WRITE;
        else if (roll < 94)
            cmd = CMD_INIT;
        else
            cmd = CMD_SPARE;
        return make_request(cmd, 8'($urandom_range(255)));
    endfunction

    // Short timing values, mostly 2 to 6 and at most 30, keep init sequences short.
    function automatic cfg_word_t short_time();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 15)
            return '0;
        if (roll < 30)
            return 16'd1;
        if (roll < 90)
            return cfg_word_t'($urandom_range(6, 2));
        return cfg_word_t'($urandom_range(30, 7));
    endfunction

    // Idle length for either side: mostly none, some short, a few long.
    // A calm stretch suppresses idling altogether.
    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(99);
        if (calm || roll < 78)
            return 0;
        if (roll < 96)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Write every timing register from timing_plan, one per clock.
    task automatic load_timing();
        for (int i = 0; i < CFG_COUNT; i++)
        begin
            @(posedge clk);
            cfg_we     <= 1'b1;
            cfg_index  <= CFG_IDX_W'(i);
            cfg_wdata  <= timing_plan[i];
            lcd_cfg[i]  = timing_plan[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Hold until every request is taken and every pin state has come back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || item_valid || expected_pins.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            mismatches++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: pop the next request, hold it while stalled,
    // insert random gaps between requests.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                expected_pins.push_back(predict_request(item));
            // A stalled request stays on the port untouched.
            if (!(item_valid && item_stall))
            begin
                if (gap_left != 0)
                begin
                    item_valid <= 1'b0;
                    gap_left   <= gap_left - 1;
                end
                else if (pending_requests.size() != 0)
                begin
                    item       <= pending_requests.pop_front();
                    item_valid <= 1'b1;
                    gap_left   <= idle_len();
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each taken pin state against the oldest
    // prediction and stall the result side at random.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_pins.size() == 0)
                begin
                    mismatches++;
                    $error("result arrived with no request outstanding");
                end
                else
                begin
                    result_t want;
                    want = expected_pins.pop_front();
                    check_field("rs_line", 8'(want.rs_line), 8'(result.rs_line));
                    check_field("enable_line", 8'(want.enable_line),
                                8'(result.enable_line));
                    check_field("data_bus", want.data_bus, result.data_bus);
                    check_field("busy_res", 8'(want.busy_res), 8'(result.busy_res));
                    check_field("initialized", 8'(want.initialized),
                                8'(result.initialized));
                    check_field("accepted", 8'(want.accepted), 8'(result.accepted));
                end
            end
            if (stall_left != 0)
            begin
                result_stall <= 1'b1;
                stall_left   <= stall_left - 1;
            end
            else
            begin
                stall_draw    = idle_len();
                result_stall <= (stall_draw != 0);
                stall_left   <= (stall_draw != 0) ? stall_draw - 1 : 0;
            end
        end
    end

    // Flip between idling and calm stretches away from the rising edge.
    always @(negedge clk)
    begin
        if ($urandom_range(299) == 0)
            calm <= ~calm;
    end

    // Watchdog: end the run if neither side moves for too long.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("char_lcd_init_write_sequencer: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < CFG_COUNT; i++)
            lcd_cfg[i] = CFG_RESET[i];
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Power-on timing: idle tick, writes before init, the spare code.
        pending_requests.push_back(make_request(CMD_TICK,  8'h00));
        pending_requests.push_back(make_request(CMD_WRITE, 8'h00));
        pending_requests.push_back(make_request(CMD_WRITE, 8'hFF));
        pending_requests.push_back(make_request(CMD_SPARE, 8'h55));
        wait_drained();

        // All zero: skipped waits, enable times acting as one tick.
        for (int i = 0; i < CFG_COUNT; i++)
            timing_plan[i] = '0;
        load_timing();
        pending_requests.push_back(make_request(CMD_INIT,  8'h00));
        // Commands while busy are refused.
        pending_requests.push_back(make_request(CMD_INIT,  8'hFF));
        pending_requests.push_back(make_request(CMD_WRITE, 8'hAA));
        pending_requests.push_back(make_request(CMD_SPARE, 8'hFF));
        // Seven init writes, two ticks each with every wait at zero.
        repeat (14) pending_requests.push_back(make_request(CMD_TICK, 8'hFF));
        pending_requests.push_back(make_request(CMD_WRITE, 8'hFF));
        pending_requests.push_back(make_request(CMD_WRITE, 8'h00));
        repeat (2) pending_requests.push_back(make_request(CMD_TICK, 8'h00));
        pending_requests.push_back(make_request(CMD_WRITE, 8'h00));
        repeat (2) pending_requests.push_back(make_request(CMD_TICK, 8'h00));
        pending_requests.push_back(make_request(CMD_SPARE, 8'h00));
        wait_drained();

        // Random timing per phase.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            for (int i = 0; i < CFG_COUNT; i++)
                timing_plan[i] = short_time();
            load_timing();
            repeat (PHASE_REQUESTS) pending_requests.push_back(random_request());
            wait_drained();
        end

        // All maximum: try a re-init and ride the start of the longest
        // power-up, with random commands scattered through it.
        for (int i = 0; i < CFG_COUNT; i++)
            timing_plan[i] = TIME_MAX;
        load_timing();
        pending_requests.push_back(make_request(CMD_INIT, 8'h00));
        for (int n = 0; n < LONG_WAIT_TICKS; n++)
        begin
            pending_requests.push_back(make_request(CMD_TICK, 8'($urandom_range(255))));
            if (n % 8 == 3)
                pending_requests.push_back(random_request());
        end
        wait_drained();

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("char_lcd_init_write_sequencer: match");
        else
            $display("char_lcd_init_write_sequencer: mismatch");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/lcdseq_pkg.sv
hw/rtl/lcdseq_step.sv
hw/rtl/char_lcd_init_write_sequencer.sv
bench/tb_top.sv
